@@ hw/rtl/umrb_pkg.sv @@
package umrb_pkg;

    // Field widths fixed by the item format
    localparam int unsigned SAMPLE_W = 32;
    localparam int unsigned CNT_W    = 7;
    localparam int unsigned CHAN_W   = 4;
    localparam int unsigned CFG_IDX_W = 1;

    // Channel count limits
    localparam logic [CHAN_W-1:0] CHAN_MIN = 4'd1;
    localparam logic [CHAN_W-1:0] CHAN_MAX = 4'd8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FORMATS_VALID   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RENDER_CHANNELS = 1'd1;

    // Operation codes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_STAT,
        S_RD,
        S_LOAD
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic push_step;
        logic push_done;
        logic rd_step;
        logic load_word;
        logic load_stat;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic in_pop;
        logic push_ok;
        logic pop_refuse;
        logic block_end;
        logic chan_last;
        logic pop_last;
        logic out_free;
    } t_status;

endpackage

@@ hw/rtl/upmix_ring_buffer.sv @@
// Ring buffer of 32-bit words that upmixes mono samples to render channels.
// Input channel (i_in_valid/o_in_ready): op 0, while formats_valid is set,
// pushes i_sample followed by render_channels-1 zero words, overwriting the
// oldest words when full; op 1 pops i_pop_count words. Output channel
// (o_out_valid/i_out_ready) gives popped words in order with o_last on the
// final one, a single o_refused item for a refused pop, and one item with
// o_overflowed for a push marked i_block_end.
// Sequence: an item is taken only in the idle state. A push then writes one
// store word per render channel (one store write port); a pop reads each
// word into a read register and then loads it into the output register
// before the next word is read. A refused pop or block-end status is loaded
// into the output register from the status state, which follows the idle
// state for a refused pop and the channel writes for a push.
// A stalled receiver holds the output register and pauses the pop; a new
// item waits until the block is idle again.
// Reset (synchronous, active low) empties the buffer, clears formats_valid
// and sets render_channels to 1; the store itself is not cleared.
// Configuration writes (i_cfg_wr_en) are allowed only while idle.
module upmix_ring_buffer #(
    parameter int unsigned DEPTH   = 1024,
    parameter int unsigned MAX_POP = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [umrb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [umrb_pkg::CHAN_W-1:0]    i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_op,
    input  logic [umrb_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic                           i_block_end,
    input  logic [umrb_pkg::CNT_W-1:0]     i_pop_count,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [umrb_pkg::SAMPLE_W-1:0]  o_data,
    output logic                           o_last,
    output logic                           o_refused,
    output logic                           o_overflowed
);
    import umrb_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    umrb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    umrb_dp #(
        .DEPTH   (DEPTH),
        .MAX_POP (MAX_POP)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_op         (i_op),
        .i_sample     (i_sample),
        .i_block_end  (i_block_end),
        .i_pop_count  (i_pop_count),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_data       (o_data),
        .o_last       (o_last),
        .o_refused    (o_refused),
        .o_overflowed (o_overflowed),
        .i_cmd        (w_cmd),
        .o_status     (w_status)
    );

endmodule

@@ hw/rtl/umrb_ctrl.sv @@
module umrb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  umrb_pkg::t_status i_status,
    output umrb_pkg::t_cmd    o_cmd
);
    import umrb_pkg::*;

    t_state r_state;
    t_state n_state;

    // Advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_status.in_pop) begin
                        n_state = i_status.pop_refuse ? S_STAT : S_RD;
                    end else if (i_status.push_ok) begin
                        n_state = S_PUSH;
                    end
                end
            end
            S_PUSH: begin
                if (i_status.chan_last) begin
                    n_state = i_status.block_end ? S_STAT : S_IDLE;
                end
            end
            S_STAT: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_RD: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (i_status.out_free) begin
                    n_state = i_status.pop_last ? S_IDLE : S_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Drive commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_PUSH: begin
                o_cmd.push_step = 1'b1;
                o_cmd.push_done = i_status.chan_last;
            end
            S_STAT: begin
                o_cmd.load_stat = i_status.out_free;
            end
            S_RD: begin
                o_cmd.rd_step = 1'b1;
            end
            S_LOAD: begin
                o_cmd.load_word = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

@@ hw/rtl/umrb_dp.sv @@
module umrb_dp #(
    parameter int unsigned DEPTH   = 1024,
    parameter int unsigned MAX_POP = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [umrb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [umrb_pkg::CHAN_W-1:0]   i_cfg_data,
    input  logic                          i_op,
    input  logic [umrb_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                          i_block_end,
    input  logic [umrb_pkg::CNT_W-1:0]    i_pop_count,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [umrb_pkg::SAMPLE_W-1:0] o_data,
    output logic                          o_last,
    output logic                          o_refused,
    output logic                          o_overflowed,
    input  umrb_pkg::t_cmd                i_cmd,
    output umrb_pkg::t_status             o_status
);
    import umrb_pkg::*;

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned FW = $clog2(DEPTH + 1);
    localparam int unsigned UW = (FW > CNT_W) ? FW : CNT_W;

    // Ring store, no reset
    logic [SAMPLE_W-1:0] r_mem [DEPTH];
    logic [SAMPLE_W-1:0] r_rdata;

    // Control state
    logic              r_fv;
    logic [CHAN_W-1:0] r_rc;
    logic [PW-1:0]     r_rd_ptr;
    logic [PW-1:0]     r_wr_ptr;
    logic [FW-1:0]     r_free;
    logic              r_ovf_seen;
    logic              r_out_valid;

    // Captured item
    logic                r_is_pop;
    logic [SAMPLE_W-1:0] r_sample;
    logic                r_block_end;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    r_cnt;

    // Output payload
    logic [SAMPLE_W-1:0] r_out_data;
    logic                r_out_last;
    logic                r_out_refused;
    logic                r_out_ovf;

    logic [PW-1:0]     w_wr_next;
    logic [PW-1:0]     w_rd_next;
    logic [FW-1:0]     w_used;
    logic              w_refuse;
    logic [CHAN_W-1:0] w_chan_sat;
    logic              w_out_free;
    logic              w_pop_last;

    assign w_wr_next = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign w_rd_next = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
    assign w_used    = FW'(DEPTH) - r_free;

    // Decide refusal of the offered pop
    assign w_refuse = !r_fv || (i_pop_count == '0)
                   || (i_pop_count > CNT_W'(MAX_POP))
                   || (UW'(i_pop_count) > UW'(w_used));

    // Saturate the channel count
    always_comb begin
        if (i_cfg_data < CHAN_MIN) begin
            w_chan_sat = CHAN_MIN;
        end else if (i_cfg_data > CHAN_MAX) begin
            w_chan_sat = CHAN_MAX;
        end else begin
            w_chan_sat = i_cfg_data;
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_pop_last = (r_cnt == r_count);

    assign o_status.in_pop     = (i_op == OP_POP);
    assign o_status.push_ok    = (i_op == OP_PUSH) && r_fv;
    assign o_status.pop_refuse = w_refuse;
    assign o_status.block_end  = r_block_end;
    assign o_status.chan_last  = ((r_cnt + 1'b1) == CNT_W'(r_rc));
    assign o_status.pop_last   = w_pop_last;
    assign o_status.out_free   = w_out_free;

    // Write and read the store
    always_ff @(posedge i_clk) begin
        if (i_cmd.push_step) begin
            r_mem[r_wr_ptr] <= (r_cnt == '0) ? r_sample : '0;
        end
        if (i_cmd.rd_step) begin
            r_rdata <= r_mem[r_rd_ptr];
        end
    end

    // Hold the captured item and step counter
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_is_pop    <= (i_op == OP_POP);
            r_sample    <= i_sample;
            r_block_end <= i_block_end;
            r_count     <= i_pop_count;
            r_cnt       <= '0;
        end else if (i_cmd.push_step || i_cmd.rd_step) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // Update configuration, pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv       <= 1'b0;
            r_rc       <= CHAN_MIN;
            r_rd_ptr   <= '0;
            r_wr_ptr   <= '0;
            r_free     <= FW'(DEPTH);
            r_ovf_seen <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                if (i_cfg_index == CFG_FORMATS_VALID) begin
                    r_fv <= i_cfg_data[0];
                end else if (i_cfg_index == CFG_RENDER_CHANNELS) begin
                    r_rc     <= w_chan_sat;
                    r_rd_ptr <= '0;
                    r_wr_ptr <= '0;
                    r_free   <= FW'(DEPTH);
                end
            end
            if (i_cmd.push_step) begin
                r_wr_ptr <= w_wr_next;
                if (i_cmd.push_done) begin
                    if (FW'(r_rc) > r_free) begin
                        r_rd_ptr   <= w_wr_next;
                        r_free     <= '0;
                        r_ovf_seen <= 1'b1;
                    end else begin
                        r_free <= r_free - FW'(r_rc);
                    end
                end
            end
            if (i_cmd.rd_step) begin
                r_rd_ptr <= w_rd_next;
            end
            if (i_cmd.load_word && w_pop_last) begin
                r_free <= r_free + FW'(r_count);
            end
            if (i_cmd.load_stat && !r_is_pop) begin
                r_ovf_seen <= 1'b0;
            end
        end
    end

    // Drive the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_word || i_cmd.load_stat) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_word) begin
            r_out_data    <= r_rdata;
            r_out_last    <= w_pop_last;
            r_out_refused <= 1'b0;
            r_out_ovf     <= 1'b0;
        end else if (i_cmd.load_stat) begin
            r_out_data    <= '0;
            r_out_last    <= 1'b1;
            r_out_refused <= r_is_pop;
            r_out_ovf     <= r_is_pop ? 1'b0 : r_ovf_seen;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_data       = r_out_data;
    assign o_last       = r_out_last;
    assign o_refused    = r_out_refused;
    assign o_overflowed = r_out_ovf;

endmodule

@@ sim/upmix_ring_buffer_tb.sv @@
module upmix_ring_buffer_tb;
    import umrb_pkg::*;

    localparam int unsigned RING_DEPTH    = 1024;
    localparam int unsigned POP_MAX       = 64;
    localparam int unsigned PTR_W         = $clog2(RING_DEPTH);
    localparam int          SETTLE_CYCLES = 40;
    localparam int          LONG_HOLD     = 400;
    localparam int          STALL_LIMIT   = 4000;
    localparam int          HOLD_AFTER    = 120;

    typedef struct packed {
        logic [SAMPLE_W-1:0] data;
        logic                last;
        logic                refused;
        logic                overflowed;
    } t_ring_out;

    // Mirror of the ring state plus the queue of outputs still owed by the block
    class ring_scoreboard;
        logic [SAMPLE_W-1:0] ring_words [RING_DEPTH];
        logic [PTR_W-1:0]    rd_ptr;
        logic [PTR_W-1:0]    wr_ptr;
        logic [PTR_W:0]      free_words;
        logic                overflow_seen;
        logic                formats_ok;
        logic [CHAN_W-1:0]   chans;
        t_ring_out           due_outputs [$];
        int                  mismatches;
        int                  results_seen;

        function new();
            empty_ring();
            overflow_seen = 1'b0;
            formats_ok    = 1'b0;
            chans         = CHAN_MIN;
            mismatches    = 0;
            results_seen  = 0;
        endfunction

        function void empty_ring();
            rd_ptr     = '0;
            wr_ptr     = '0;
            free_words = (PTR_W+1)'(RING_DEPTH);
        endfunction

        function logic [PTR_W-1:0] advance(logic [PTR_W-1:0] p);
            return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
        endfunction

        function int stored_words();
            return int'(RING_DEPTH) - int'(free_words);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CHAN_W-1:0] value);
            if (index == CFG_FORMATS_VALID) begin
                formats_ok = value[0];
            end else if (index == CFG_RENDER_CHANNELS) begin
                // Saturate the channel count, then empty the ring
                if (value < CHAN_MIN)
                    chans = CHAN_MIN;
                else if (value > CHAN_MAX)
                    chans = CHAN_MAX;
                else
                    chans = value;
                empty_ring();
            end
        endfunction

        function void note_accepted(logic op, logic [SAMPLE_W-1:0] sample, logic block_end,
                                    logic [CNT_W-1:0] count);
            t_ring_out res;
            int        i;
            int        used;
            if (op == OP_PUSH) begin
                if (!formats_ok)
                    return;
                // Store the sample, then zero fill for the other channels
                for (i = 0; i < int'(chans); i++) begin
                    ring_words[wr_ptr] = (i == 0) ? sample : '0;
                    wr_ptr = advance(wr_ptr);
                end
                if (int'(chans) > int'(free_words)) begin
                    rd_ptr        = wr_ptr;
                    free_words    = '0;
                    overflow_seen = 1'b1;
                end else begin
                    free_words = free_words - (PTR_W+1)'(chans);
                end
                if (block_end) begin
                    res.data       = '0;
                    res.last       = 1'b1;
                    res.refused    = 1'b0;
                    res.overflowed = overflow_seen;
                    due_outputs.push_back(res);
                    overflow_seen = 1'b0;
                end
                return;
            end
            used = stored_words();
            if (!formats_ok || count == 0 || int'(count) > int'(POP_MAX) ||
                int'(count) > used) begin
                res.data       = '0;
                res.last       = 1'b1;
                res.refused    = 1'b1;
                res.overflowed = 1'b0;
                due_outputs.push_back(res);
                return;
            end
            for (i = 0; i < int'(count); i++) begin
                res.data       = ring_words[rd_ptr];
                res.last       = (i == int'(count) - 1);
                res.refused    = 1'b0;
                res.overflowed = 1'b0;
                due_outputs.push_back(res);
                rd_ptr = advance(rd_ptr);
            end
            free_words = free_words + (PTR_W+1)'(count);
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            mismatches++;
        endtask

        task check_result(logic [SAMPLE_W-1:0] data, logic last, logic refused, logic ovf);
            t_ring_out want;
            results_seen++;
            if (due_outputs.size() == 0) begin
                report($sformatf("result %0d arrived with nothing pending", results_seen));
                return;
            end
            want = due_outputs.pop_front();
            if (data !== want.data)
                report($sformatf("result %0d data %h, want %h", results_seen, data, want.data));
            if (last !== want.last)
                report($sformatf("result %0d last %b, want %b", results_seen, last, want.last));
            if (refused !== want.refused)
                report($sformatf("result %0d refused %b, want %b", results_seen, refused,
                                 want.refused));
            if (ovf !== want.overflowed)
                report($sformatf("result %0d overflowed %b, want %b", results_seen, ovf,
                                 want.overflowed));
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CHAN_W-1:0]     i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic                  i_op;
    logic [SAMPLE_W-1:0]   i_sample;
    logic                  i_block_end;
    logic [CNT_W-1:0]      i_pop_count;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [SAMPLE_W-1:0]   o_data;
    logic                  o_last;
    logic                  o_refused;
    logic                  o_overflowed;

    ring_scoreboard sb = new();
    bit             long_hold_done = 1'b0;
    int             quiet_cycles = 0;

    upmix_ring_buffer #(
        .DEPTH   (RING_DEPTH),
        .MAX_POP (POP_MAX)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_op         (i_op),
        .i_sample     (i_sample),
        .i_block_end  (i_block_end),
        .i_pop_count  (i_pop_count),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_data       (o_data),
        .o_last       (o_last),
        .o_refused    (o_refused),
        .o_overflowed (o_overflowed)
    );

    always #1 i_clk = ~i_clk;

    // Mostly short gaps, a few long ones, and plenty of back-to-back cycles
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99, 0);
        if (r < 45)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int r;
        r = $urandom_range(7, 0);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return $urandom();
    endfunction

    // Offer one item and hold it until the block takes it
    task automatic send_item(logic op, logic [SAMPLE_W-1:0] sample, logic block_end,
                             logic [CNT_W-1:0] count);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_op        <= op;
        i_sample    <= sample;
        i_block_end <= block_end;
        i_pop_count <= count;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        sb.note_accepted(op, sample, block_end, count);
    endtask

    task automatic send_push(logic [SAMPLE_W-1:0] sample, logic block_end);
        send_item(OP_PUSH, sample, block_end, CNT_W'($urandom()));
    endtask

    task automatic send_pop(logic [CNT_W-1:0] count);
        send_item(OP_POP, $urandom(), 1'($urandom()), count);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] index, logic [CHAN_W-1:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        sb.write_reg(index, value);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    // Stop offering, wait for every owed output, then let trailing channel writes finish
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.due_outputs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Random traffic: pops mostly sized to what is stored, some noise counts
    task automatic run_phase(int n_items, int push_pct, int pop_cap);
        int k;
        int used;
        int cap;
        for (k = 0; k < n_items; k++) begin
            if ($urandom_range(99, 0) < push_pct) begin
                send_push(pick_sample(), ($urandom_range(7, 0) == 0));
            end else if ($urandom_range(9, 0) == 0) begin
                send_pop(CNT_W'($urandom_range(127, 0)));
            end else begin
                used = sb.stored_words();
                cap  = (used < pop_cap) ? used : pop_cap;
                if (cap < 1)
                    send_pop(CNT_W'($urandom_range(3, 1)));
                else
                    send_pop(CNT_W'($urandom_range(cap, 1)));
            end
        end
    endtask

    // Check every output item the receiver takes
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_data, o_last, o_refused, o_overflowed);
    end

    // End the run if nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_wr_en)
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("upmix_ring_buffer verification failed");
            $finish;
        end
    end

    // Receiver: random ready bursts and gaps, plus one long hold while items are offered
    initial begin : out_ready_driver
        int run_len;
        int gap_len;
        i_out_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (!long_hold_done && sb.results_seen >= HOLD_AFTER && i_in_valid) begin
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_hold_done = 1'b1;
            end else begin
                run_len = $urandom_range(30, 1);
                i_out_ready <= 1'b1;
                repeat (run_len) @(posedge i_clk);
                gap_len = pick_gap();
                if (gap_len > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (gap_len) @(posedge i_clk);
                end
            end
        end
    end

    initial begin : stimulus
        int i;
        i_rst_n     <= 1'b0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_op        <= OP_PUSH;
        i_sample    <= '0;
        i_block_end <= 1'b0;
        i_pop_count <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Formats invalid after reset: pop refused, block-end push ignored
        send_pop(CNT_W'(1));
        send_push(32'hDEAD_BEEF, 1'b1);
        drain();
        write_cfg(CFG_FORMATS_VALID, 4'h1);
        write_cfg(CFG_RENDER_CHANNELS, 4'h0);

        // One channel: empty pop, extreme samples, bad counts, exact pop
        send_pop(CNT_W'(1));
        send_push('1, 1'b0);
        send_push('0, 1'b0);
        send_push(32'h5A5A_5A5A, 1'b1);
        send_pop(CNT_W'(0));
        send_pop(CNT_W'(127));
        send_pop(CNT_W'(65));
        send_pop(CNT_W'(4));
        send_pop(CNT_W'(3));
        drain();

        // Saturated to eight channels: fill 64 words, pop the largest run twice
        write_cfg(CFG_RENDER_CHANNELS, 4'hF);
        for (i = 0; i < 8; i++)
            send_push(32'h1000_0000 + i, (i == 7));
        send_pop(CNT_W'(POP_MAX));
        send_pop(CNT_W'(POP_MAX));

        // Channel write empties the ring
        send_push(32'h1234_5678, 1'b0);
        drain();
        write_cfg(CFG_RENDER_CHANNELS, 4'h7);
        send_pop(CNT_W'(1));
        drain();

        // Push-heavy at eight channels so the ring wraps and overwrites
        write_cfg(CFG_RENDER_CHANNELS, 4'h8);
        run_phase(150, 97, 4);
        drain();
        write_cfg(CFG_RENDER_CHANNELS, 4'h3);
        run_phase(60, 55, POP_MAX);
        drain();
        write_cfg(CFG_RENDER_CHANNELS, 4'h1);
        run_phase(50, 50, POP_MAX);
        drain();

        // Formats invalid again with data still stored
        write_cfg(CFG_FORMATS_VALID, 4'hE);
        run_phase(20, 50, POP_MAX);
        drain();
        write_cfg(CFG_FORMATS_VALID, 4'hF);
        write_cfg(CFG_RENDER_CHANNELS, 4'h9);
        run_phase(60, 60, POP_MAX);
        drain();
        write_cfg(CFG_RENDER_CHANNELS, 4'h2);
        run_phase(50, 55, POP_MAX);
        drain();

        if (sb.due_outputs.size() != 0)
            sb.report($sformatf("%0d outputs never arrived", sb.due_outputs.size()));
        if (sb.mismatches == 0)
            $display("upmix_ring_buffer verification clean");
        else
            $display("upmix_ring_buffer verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/umrb_pkg.sv
hw/rtl/umrb_ctrl.sv
hw/rtl/umrb_dp.sv
hw/rtl/upmix_ring_buffer.sv
sim/upmix_ring_buffer_tb.sv
